### rtl/alu_execute_with_flags_macros.svh
// Assertion macros for the execute block.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef ALU_EXECUTE_WITH_FLAGS_MACROS_SVH
`define ALU_EXECUTE_WITH_FLAGS_MACROS_SVH

// Plain property on the block clock, muted during reset
`define ALUX_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in this cycle implies expression in the next
`define ALUX_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

### rtl/alux_pkg.sv
// Shared types and constants of the ALU execute block.
// No dependencies; imported by every module of the block.
package alux_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 80;
  localparam int VALUE_W     = 64;

  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_SUB   = 4'd1,
    KIND_CMP   = 4'd2,
    KIND_MOVE  = 4'd3,
    KIND_AND   = 4'd4,
    KIND_OR    = 4'd5,
    KIND_XOR   = 4'd6,
    KIND_SHIFT = 4'd7,
    KIND_CTEST = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    COND_EQ  = 3'd0,
    COND_NE  = 3'd1,
    COND_SGT = 3'd2,
    COND_SLT = 3'd3,
    COND_UGT = 3'd4,
    COND_UGE = 3'd5,
    COND_ULT = 3'd6,
    COND_OV  = 3'd7
  } cond_t;

  // Status flags, Z in bit 0 up to N in bit 3
  typedef struct packed {
    logic n;
    logic v;
    logic c;
    logic z;
  } flags_t;

  // One decoded instruction; last member sits in the lowest bits,
  // so the struct maps directly onto the input tdata layout
  typedef struct packed {
    cond_t        cond_code;
    logic [5:0]   shift_amount;
    logic         shift_right;
    logic [63:0]  imm_value;
    logic         use_imm;
    logic [2:0]   src_b_reg;
    logic [2:0]   src_a_reg;
    logic [2:0]   dest_reg;
    kind_t        kind;
  } item_t;

endpackage

### rtl/alux_regfile.sv
// Register file memory: two synchronous read ports, one write port.
// Per-entry valid bits give the reset value; same-edge writes bypass to reads.
module alux_regfile import alux_pkg::*; #(
  parameter int DATA_WIDTH = 64,
  parameter int NUM_REGS   = 8,
  parameter int IDX_W      = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_a_addr,
  input  logic [IDX_W-1:0]      rd_b_addr,
  output logic [DATA_WIDTH-1:0] rd_a_data,
  output logic [DATA_WIDTH-1:0] rd_b_data,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data
);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]   written;
  logic [DATA_WIDTH-1:0] a_q;
  logic [DATA_WIDTH-1:0] b_q;
  logic                  a_vld;
  logic                  b_vld;
  logic                  hit_a;
  logic                  hit_b;

  assign hit_a = wr_en && (wr_addr == rd_a_addr);
  assign hit_b = wr_en && (wr_addr == rd_b_addr);

  // Entry-written bits: cleared by reset, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered reads; a write at the same edge is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_q   <= hit_a ? wr_data : mem[rd_a_addr];
      b_q   <= hit_b ? wr_data : mem[rd_b_addr];
      a_vld <= hit_a || written[rd_a_addr];
      b_vld <= hit_b || written[rd_b_addr];
    end
  end

  assign rd_a_data = a_vld ? a_q : '0;
  assign rd_b_data = b_vld ? b_q : '0;

endmodule

### rtl/alux_core.sv
// Execute datapath: add/sub/logic/shift, flag update and condition check.
// Purely combinational; depends on alux_pkg types.
module alux_core import alux_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  item_t                 item,
  input  logic [DATA_WIDTH-1:0] opa,
  input  logic [DATA_WIDTH-1:0] opb,
  input  flags_t                flags,
  output logic                  wr,
  output logic [DATA_WIDTH-1:0] result,
  output flags_t                flags_next,
  output logic                  cond_holds
);

  localparam int MSB = DATA_WIDTH - 1;

  logic [DATA_WIDTH:0]        sum;
  logic [DATA_WIDTH:0]        diff;
  logic [DATA_WIDTH:0]        lsh;
  logic signed [DATA_WIDTH:0] rsh;
  logic [DATA_WIDTH-1:0]      sh_res;
  logic                       sh_c;
  logic                       add_v;
  logic                       sub_v;

  // Adder and subtractor with carry/borrow in the top bit
  assign sum   = {1'b0, opa} + {1'b0, opb};
  assign diff  = {1'b0, opa} - {1'b0, opb};
  assign add_v = (opa[MSB] ^ sum[MSB]) & (opb[MSB] ^ sum[MSB]);
  assign sub_v = (opa[MSB] ^ opb[MSB]) & (opa[MSB] ^ diff[MSB]);

  // Shifter: one guard bit catches the last bit shifted out
  assign lsh    = {1'b0, opa} << item.shift_amount;
  assign rsh    = $signed({opa, 1'b0}) >>> item.shift_amount;
  assign sh_res = item.shift_right ? rsh[DATA_WIDTH:1] : lsh[DATA_WIDTH-1:0];
  assign sh_c   = item.shift_right ? rsh[0] : lsh[DATA_WIDTH];

  // Result select and flag update
  always_comb begin
    wr         = 1'b0;
    result     = '0;
    flags_next = flags;
    unique case (item.kind)
      KIND_ADD: begin
        wr         = 1'b1;
        result     = sum[DATA_WIDTH-1:0];
        flags_next = '{n: result[MSB], v: add_v, c: sum[DATA_WIDTH], z: (result == '0)};
      end
      KIND_SUB, KIND_CMP: begin
        wr         = (item.kind == KIND_SUB);
        result     = diff[DATA_WIDTH-1:0];
        flags_next = '{n: result[MSB], v: sub_v, c: diff[DATA_WIDTH], z: (result == '0)};
      end
      KIND_MOVE: begin
        wr     = 1'b1;
        result = opb;
      end
      KIND_AND, KIND_OR, KIND_XOR: begin
        wr = 1'b1;
        if (item.kind == KIND_AND) begin
          result = opa & opb;
        end else if (item.kind == KIND_OR) begin
          result = opa | opb;
        end else begin
          result = opa ^ opb;
        end
        flags_next.n = result[MSB];
        flags_next.c = 1'b0;
        flags_next.z = (result == '0);
      end
      KIND_SHIFT: begin
        wr           = 1'b1;
        result       = sh_res;
        flags_next.c = sh_c;
        flags_next.z = (result == '0);
      end
      default: begin
        // condition test and unused kinds: no write, flags kept
        wr = 1'b0;
      end
    endcase
  end

  // Condition on the updated flags
  always_comb begin
    unique case (item.cond_code)
      COND_EQ:  cond_holds = flags_next.z;
      COND_NE:  cond_holds = !flags_next.z;
      COND_SGT: cond_holds = !flags_next.z && (flags_next.n == flags_next.v);
      COND_SLT: cond_holds = !flags_next.z && (flags_next.n != flags_next.v);
      COND_UGT: cond_holds = !flags_next.c && !flags_next.z;
      COND_UGE: cond_holds = !flags_next.c;
      COND_ULT: cond_holds = flags_next.c;
      COND_OV:  cond_holds = flags_next.v;
      default:  cond_holds = 1'b0;
    endcase
  end

endmodule

### rtl/alu_execute_with_flags.sv
// Channel | Dir | Signals                    | Item
// s_axis  | in  | tvalid, tready, tdata[87:0]| one decoded instruction
// m_axis  | out | tvalid, tready, tdata[79:0]| write-back, flags, condition
//
// From input accept to result: register file read, then execute.
// One item per clock unless stalled; a write-back is forwarded at the
// register file read port, so dependent instructions follow back to back.
// Synchronous reset clears pipeline valids, flags and register valid bits.
// A stalled output holds the execute stage, which holds the input.
//
// Top level of the ALU execute block; uses alux_pkg, alux_regfile, alux_core
// and the assertion macros header.
`include "alu_execute_with_flags_macros.svh"

module alu_execute_with_flags import alux_pkg::*; #(
  parameter int DATA_WIDTH = 64,
  parameter int NUM_REGS   = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // kind[3:0], dest_reg[6:4], src_a_reg[9:7], src_b_reg[12:10], use_imm[13],
  // imm_value[77:14], shift_right[78], shift_amount[84:79], cond_code[87:85]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // write_enable[0], write_reg[3:1], write_value[67:4], zero_flag[68],
  // carry_flag[69], overflow_flag[70], negative_flag[71], cond_holds[72],
  // zero fill [79:73]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [4:0] NUM_REGS_L = 5'(NUM_REGS);

  item_t                 in_item;
  logic                  accept;
  logic                  ex_fire;

  logic                  s1_valid;
  item_t                 s1_item;
  logic                  s1_a_ok;
  logic                  s1_b_ok;
  logic                  s1_dest_ok;

  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic                  rf_wr_en;

  flags_t                flags;
  flags_t                flags_next;
  logic                  core_wr;
  logic [DATA_WIDTH-1:0] core_result;
  logic                  core_cond;

  logic                  o_we;
  logic [2:0]            o_wreg;
  logic [VALUE_W-1:0]    o_wval;
  flags_t                o_flags;
  logic                  o_cond;

  // Handshakes
  assign in_item       = item_t'(s_axis_tdata);
  assign ex_fire       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || ex_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Read stage: item waits here while the register file is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (ex_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item    <= in_item;
      s1_a_ok    <= {2'b00, in_item.src_a_reg} < NUM_REGS_L;
      s1_b_ok    <= {2'b00, in_item.src_b_reg} < NUM_REGS_L;
      s1_dest_ok <= {2'b00, in_item.dest_reg} < NUM_REGS_L;
    end
  end

  alux_regfile #(
    .DATA_WIDTH (DATA_WIDTH),
    .NUM_REGS   (NUM_REGS),
    .IDX_W      (IDX_W)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_a_addr (IDX_W'(in_item.src_a_reg)),
    .rd_b_addr (IDX_W'(in_item.src_b_reg)),
    .rd_a_data (rd_a),
    .rd_b_data (rd_b),
    .wr_en     (rf_wr_en),
    .wr_addr   (IDX_W'(s1_item.dest_reg)),
    .wr_data   (core_result)
  );

  // Operand select; out-of-range registers read as zero
  assign opa = s1_a_ok ? rd_a : '0;
  assign opb = s1_item.use_imm ? s1_item.imm_value[DATA_WIDTH-1:0] :
               (s1_b_ok ? rd_b : '0);

  alux_core #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .item       (s1_item),
    .opa        (opa),
    .opb        (opb),
    .flags      (flags),
    .wr         (core_wr),
    .result     (core_result),
    .flags_next (flags_next),
    .cond_holds (core_cond)
  );

  assign rf_wr_en = ex_fire && core_wr && s1_dest_ok;

  // Status flags
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (ex_fire) begin
      flags <= flags_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ex_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      o_we    <= rf_wr_en;
      o_wreg  <= rf_wr_en ? s1_item.dest_reg : 3'd0;
      o_wval  <= rf_wr_en ? VALUE_W'(core_result) : '0;
      o_flags <= flags_next;
      o_cond  <= core_cond;
    end
  end

  assign m_axis_tdata = {7'd0, o_cond, o_flags, o_wval, o_wreg, o_we};

  // Checks
  `ALUX_ASSERT_NEXT(a_exec_shown, ex_fire, m_axis_tvalid, "executed item not presented")
  `ALUX_ASSERT_NEXT(a_stall_holds, s1_valid && !ex_fire, s1_valid && $stable(s1_item), "read stage lost item")
  `ALUX_ASSERT_NEXT(a_wb_reported, rf_wr_en, m_axis_tdata[0] && (m_axis_tdata[3:1] == $past(s1_item.dest_reg)), "register write not reported")
  `ALUX_ASSERT_CLK(a_flags_match, m_axis_tvalid |-> (m_axis_tdata[71:68] == flags), "shown flags differ from state")
  `ALUX_ASSERT_CLK(a_nowr_zero, (m_axis_tvalid && !o_we) |-> ((o_wreg == 3'd0) && (o_wval == '0)), "write fields not cleared")

endmodule
